### hw/rtl/bpet_pkg.sv
// Shared types and constants for the button press edge tracker.
`default_nettype none

package bpet_pkg;

    // Field widths of one transaction
    localparam int KEY_W      = 9;
    localparam int BTN_IDX_W  = 5;
    localparam int KIND_W     = 2;
    localparam int LEVEL_W    = 3;
    localparam int MAX_SLOTS  = 2 ** BTN_IDX_W;

    // Key code typed at the console (all ones)
    localparam logic [KEY_W-1:0] KEY_CONSOLE = '1;
    localparam logic [KEY_W-1:0] KEY_EMPTY   = '0;

    // Flag bit positions
    localparam int FLAG_HELD = 0;
    localparam int FLAG_DOWN = 1;
    localparam int FLAG_UP   = 2;

    // Sample levels in quarters
    localparam logic [LEVEL_W-1:0] LVL_ZERO  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_QUART = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_HALF  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_3QUART = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_FULL  = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SAMPLE  = 2'd2
    } t_kind;

    // One button table entry
    typedef struct packed {
        logic [2:0]       flags;
        logic [KEY_W-1:0] second_key;
        logic [KEY_W-1:0] first_key;
    } t_entry;

    // One result item
    typedef struct packed {
        logic               slots_full;
        logic [LEVEL_W-1:0] level_quarters;
        logic               held;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/bpet_table.sv
// Button table register file: one combinational read port, one write port.
`default_nettype none

module bpet_table #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire [IDX_W-1:0]      i_rd_idx,
    output bpet_pkg::t_entry     o_rd_entry,
    input  wire                  i_wr_en,
    input  wire [IDX_W-1:0]      i_wr_idx,
    input  wire bpet_pkg::t_entry i_wr_entry
);
    import bpet_pkg::*;

    t_entry r_mem [DEPTH];

    // Read the addressed entry
    assign o_rd_entry = r_mem[i_rd_idx];

    // Clear all entries on reset, write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bpet_update.sv
// Next-entry and result logic for one press, release or sample event.
`default_nettype none

module bpet_update (
    input  wire bpet_pkg::t_entry            i_entry,
    input  wire [bpet_pkg::KIND_W-1:0]       i_kind,
    input  wire [bpet_pkg::KEY_W-1:0]        i_key,
    output bpet_pkg::t_entry                 o_entry,
    output bpet_pkg::t_result                o_result
);
    import bpet_pkg::*;

    logic               w_held;
    logic               w_dn;
    logic               w_up;
    logic [LEVEL_W-1:0] w_level;

    assign w_held = i_entry.flags[FLAG_HELD];
    assign w_dn   = i_entry.flags[FLAG_DOWN];
    assign w_up   = i_entry.flags[FLAG_UP];

    // Map held and edge latches to a level in quarters
    always_comb begin
        unique case ({w_dn, w_up})
            2'b10:   w_level = w_held ? LVL_HALF   : LVL_ZERO;
            2'b00:   w_level = w_held ? LVL_FULL   : LVL_ZERO;
            2'b11:   w_level = w_held ? LVL_3QUART : LVL_QUART;
            default: w_level = LVL_ZERO;
        endcase
    end

    // Apply the event to the entry
    always_comb begin
        o_entry  = i_entry;
        o_result = '0;
        unique case (t_kind'(i_kind))
            KIND_PRESS: begin
                if (i_key != i_entry.first_key && i_key != i_entry.second_key) begin
                    priority if (i_entry.first_key == KEY_EMPTY) begin
                        o_entry.first_key = i_key;
                    end else if (i_entry.second_key == KEY_EMPTY) begin
                        o_entry.second_key = i_key;
                    end else begin
                        o_result.slots_full = 1'b1;
                    end
                    // First press latches held and the down edge
                    if (!o_result.slots_full && !w_held) begin
                        o_entry.flags[FLAG_HELD] = 1'b1;
                        o_entry.flags[FLAG_DOWN] = 1'b1;
                    end
                end
            end
            KIND_RELEASE: begin
                if (i_key == KEY_CONSOLE) begin
                    // Console release drops both keys
                    o_entry.first_key  = KEY_EMPTY;
                    o_entry.second_key = KEY_EMPTY;
                    o_entry.flags      = 3'b000;
                    o_entry.flags[FLAG_UP] = 1'b1;
                end else if (i_entry.first_key == i_key ||
                             i_entry.second_key == i_key) begin
                    if (i_entry.first_key == i_key) begin
                        o_entry.first_key = KEY_EMPTY;
                    end else begin
                        o_entry.second_key = KEY_EMPTY;
                    end
                    // Last key gone: drop held, latch the up edge
                    if (o_entry.first_key == KEY_EMPTY &&
                        o_entry.second_key == KEY_EMPTY && w_held) begin
                        o_entry.flags[FLAG_HELD] = 1'b0;
                        o_entry.flags[FLAG_UP]   = 1'b1;
                    end
                end
            end
            KIND_SAMPLE: begin
                o_result.level_quarters  = w_level;
                o_entry.flags[FLAG_DOWN] = 1'b0;
                o_entry.flags[FLAG_UP]   = 1'b0;
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
        o_result.held = o_entry.flags[FLAG_HELD];
    end

endmodule

`default_nettype wire

### hw/rtl/button_press_edge_tracker.sv
// Top level of the button press edge tracker.
//
// Input stream (s_axis): one event per transaction. tuser carries the kind
// (press, release, sample); tdata carries button_index in bits [4:0] and
// key_code in bits [13:5]. A key_code of all ones is the console key.
// Output stream (m_axis): one result per event. tdata bit 0 is held,
// bits [3:1] the sample level in quarters, bit 4 the slots-full flag.
// Each event is registered in the input register, where the read-modify-write of
// its button table entry is done, and its result is registered in the output
// register; one event per cycle is sustained while the receiver does not stall.
// The per-cycle rate is set by the single read and write port of the button table.
// Reset clears all key slots and flags at once; the block accepts events
// in the first cycle after reset is released. When the receiver stalls,
// one result waits in the output register and one event in the input
// register; s_axis_tready then drops until the result is taken.
// Events for a button index at or above NUM_BUTTONS leave the table alone
// and return an all-zero result.
`default_nettype none

module button_press_edge_tracker #(
    parameter int NUM_BUTTONS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // button_index[4:0], key_code[13:5], zero[15:14]
    input  wire  [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // held[0], level_quarters[3:1], slots_full[4], zero[7:5]
);
    import bpet_pkg::*;

    localparam int DEPTH = (NUM_BUTTONS < MAX_SLOTS) ? NUM_BUTTONS : MAX_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 r_in_valid, n_in_valid;
    logic [KIND_W-1:0]    r_in_kind,  n_in_kind;
    logic [BTN_IDX_W-1:0] r_in_idx,   n_in_idx;
    logic [KEY_W-1:0]     r_in_key,   n_in_key;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic       w_in_take;
    logic       w_fire;
    logic       w_in_range;
    logic [IDX_W-1:0] w_sel;
    t_entry     w_rd_entry;
    t_entry     w_wr_entry;
    t_result    w_result;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign w_in_range    = 32'(r_in_idx) < NUM_BUTTONS;
    assign w_sel         = w_in_range ? IDX_W'(r_in_idx) : '0;

    bpet_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (w_sel),
        .o_rd_entry (w_rd_entry),
        .i_wr_en    (w_fire && w_in_range),
        .i_wr_idx   (w_sel),
        .i_wr_entry (w_wr_entry)
    );

    bpet_update u_update (
        .i_entry  (w_rd_entry),
        .i_kind   (r_in_kind),
        .i_key    (r_in_key),
        .o_entry  (w_wr_entry),
        .o_result (w_result)
    );

    // Advance the input and result registers
    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_kind   = r_in_kind;
        n_in_idx    = r_in_idx;
        n_in_key    = r_in_key;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_fire) begin
            n_in_valid  = 1'b0;
            n_out_valid = 1'b1;
            n_out       = w_in_range ? w_result : '0;
        end
        if (w_in_take) begin
            n_in_valid = 1'b1;
            n_in_kind  = s_axis_tuser;
            n_in_idx   = s_axis_tdata[BTN_IDX_W-1:0];
            n_in_key   = s_axis_tdata[BTN_IDX_W+KEY_W-1:BTN_IDX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge i_clk) begin
        r_in_kind <= n_in_kind;
        r_in_idx  <= n_in_idx;
        r_in_key  <= n_in_key;
        r_out     <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    // Refused press never reports a level
    a_full_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:1] == LVL_ZERO)
        else $error("slots_full result carries a level");

    // Level never above one
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:1] <= LVL_FULL)
        else $error("level above full scale");

    // Half and full levels come only from a held button
    a_level_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:1] == LVL_HALF || m_axis_tdata[3:1] == LVL_FULL)
        |-> m_axis_tdata[0])
        else $error("held level without held flag");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a stalled result");

    // A processed event yields a result in the next cycle
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> m_axis_tvalid)
        else $error("processed event produced no result");

endmodule

`default_nettype wire
